// ----- hw/rtl/lsu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsu_pkg: shared types and constants of the SET/UA link set-up block
// Field widths, operation and result codes, state encodings, the register map
// and the reset values of the configuration registers.
// ----------------------------------------------------------------------------
package lsu_pkg;

    localparam int OpW      = 2;
    localparam int ByteW    = 8;
    localparam int KindW    = 2;
    localparam int AttW     = 4;
    localparam int CfgAddrW = 3;
    localparam int IdxW     = 3;

    // position of the closing flag within the five-byte SET frame
    localparam logic [IdxW-1:0] FrameLastIdx = 3'd4;

    // input operations
    typedef enum logic [OpW-1:0] {
        OP_START = 2'd0,
        OP_RX    = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    // kinds of result item
    typedef enum logic [KindW-1:0] {
        RK_TX   = 2'd0,
        RK_UP   = 2'd1,
        RK_FAIL = 2'd2
    } t_kind;

    // handshake phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_UP   = 2'd2,
        PH_FAIL = 2'd3
    } t_phase;

    // UA frame recogniser
    typedef enum logic [2:0] {
        RS_START = 3'd0,
        RS_FLAG  = 3'd1,
        RS_ADDR  = 3'd2,
        RS_CTRL  = 3'd3,
        RS_BCC   = 3'd4
    } t_rec;

    // burst of results raised by one item
    typedef enum logic [1:0] {
        BURST_NONE = 2'd0,
        BURST_SET  = 2'd1,
        BURST_UP   = 2'd2,
        BURST_FAIL = 2'd3
    } t_burst;

    // register map
    typedef enum logic [CfgAddrW-1:0] {
        CA_FLAG       = 3'd0,
        CA_SET_ADDR   = 3'd1,
        CA_SET_CTRL   = 3'd2,
        CA_REPLY_ADDR = 3'd3,
        CA_REPLY_CTRL = 3'd4,
        CA_TIMEOUT    = 3'd5,
        CA_MAX_ATT    = 3'd6
    } t_cfg_addr;

    typedef struct packed {
        logic [ByteW-1:0] flag;
        logic [ByteW-1:0] set_addr;
        logic [ByteW-1:0] set_ctrl;
        logic [ByteW-1:0] reply_addr;
        logic [ByteW-1:0] reply_ctrl;
        logic [ByteW-1:0] timeout;
        logic [AttW-1:0]  max_att;
    } t_cfg;

    localparam logic [ByteW-1:0] FlagReset      = 8'h7e;
    localparam logic [ByteW-1:0] SetAddrReset   = 8'h03;
    localparam logic [ByteW-1:0] SetCtrlReset   = 8'h03;
    localparam logic [ByteW-1:0] ReplyAddrReset = 8'h01;
    localparam logic [ByteW-1:0] ReplyCtrlReset = 8'h07;
    localparam logic [ByteW-1:0] TimeoutReset   = 8'd5;
    localparam logic [AttW-1:0]  MaxAttReset    = 4'd4;

endpackage

// ----- hw/rtl/lsu_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsu_if: handshake channels of the SET/UA link set-up block
// Input items, result items and configuration writes, each with valid/ready.
// ----------------------------------------------------------------------------
interface lsu_in_if;
    logic                        valid;
    logic                        ready;
    logic [lsu_pkg::OpW-1:0]     opcode;
    logic [lsu_pkg::ByteW-1:0]   rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface lsu_out_if;
    logic                        valid;
    logic                        ready;
    logic [lsu_pkg::KindW-1:0]   result_kind;
    logic [lsu_pkg::ByteW-1:0]   tx_byte;
    logic                        last;

    modport source (output valid, output result_kind, output tx_byte, output last,
                    input ready);
    modport sink   (input valid, input result_kind, input tx_byte, input last,
                    output ready);
endinterface

interface lsu_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [lsu_pkg::CfgAddrW-1:0] addr;
    logic [lsu_pkg::ByteW-1:0]    data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

// ----- hw/rtl/lsu_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsu_cfg: configuration register file
// Seven registers written one at a time; writes beyond the map are dropped.
// ----------------------------------------------------------------------------
module lsu_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr,
    input  logic [lsu_pkg::CfgAddrW-1:0] i_addr,
    input  logic [lsu_pkg::ByteW-1:0]    i_data,
    output logic                         o_ready,
    output lsu_pkg::t_cfg                o_cfg
);
    import lsu_pkg::*;

    t_cfg r_cfg;

    // always able to take a write
    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    // write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag       <= FlagReset;
            r_cfg.set_addr   <= SetAddrReset;
            r_cfg.set_ctrl   <= SetCtrlReset;
            r_cfg.reply_addr <= ReplyAddrReset;
            r_cfg.reply_ctrl <= ReplyCtrlReset;
            r_cfg.timeout    <= TimeoutReset;
            r_cfg.max_att    <= MaxAttReset;
        end else if (i_wr) begin
            case (t_cfg_addr'(i_addr))
                CA_FLAG:       r_cfg.flag       <= i_data;
                CA_SET_ADDR:   r_cfg.set_addr   <= i_data;
                CA_SET_CTRL:   r_cfg.set_ctrl   <= i_data;
                CA_REPLY_ADDR: r_cfg.reply_addr <= i_data;
                CA_REPLY_CTRL: r_cfg.reply_ctrl <= i_data;
                CA_TIMEOUT:    r_cfg.timeout    <= i_data;
                CA_MAX_ATT:    r_cfg.max_att    <= i_data[AttW-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/lsu_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsu_core: handshake state and UA recogniser
// Updates phase, recogniser, tick count and attempt count for each accepted
// item and names the burst of results that the item raises.
// ----------------------------------------------------------------------------
module lsu_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic [lsu_pkg::OpW-1:0]    i_opcode,
    input  logic [lsu_pkg::ByteW-1:0]  i_rx_byte,
    input  lsu_pkg::t_cfg              i_cfg,
    output lsu_pkg::t_burst            o_burst
);
    import lsu_pkg::*;

    t_phase           r_phase, n_phase;
    t_rec             r_rec, n_rec;
    logic [ByteW-1:0] r_ticks, n_ticks;
    logic [AttW-1:0]  r_att, n_att;

    t_rec             w_rec_step;
    logic             w_hit;
    logic             w_wait;
    logic [ByteW-1:0] w_reload;
    logic [AttW-1:0]  w_limit;
    logic [ByteW-1:0] w_check;

    assign w_wait   = (r_phase == PH_WAIT);
    assign w_reload = (i_cfg.timeout == '0) ? ByteW'(1) : i_cfg.timeout;
    assign w_limit  = (i_cfg.max_att == '0) ? AttW'(1) : i_cfg.max_att;
    assign w_check  = i_cfg.reply_addr ^ i_cfg.reply_ctrl;

    // advance the recogniser by one received byte
    always_comb begin
        w_rec_step = RS_START;
        w_hit      = 1'b0;
        case (r_rec)
            RS_START: begin
                if (i_rx_byte == i_cfg.flag) w_rec_step = RS_FLAG;
            end
            RS_FLAG: begin
                if (i_rx_byte == i_cfg.reply_addr)  w_rec_step = RS_ADDR;
                else if (i_rx_byte == i_cfg.flag)   w_rec_step = RS_FLAG;
            end
            RS_ADDR: begin
                if (i_rx_byte == i_cfg.flag)             w_rec_step = RS_FLAG;
                else if (i_rx_byte == i_cfg.reply_ctrl)  w_rec_step = RS_CTRL;
            end
            RS_CTRL: begin
                if (i_rx_byte == i_cfg.flag)  w_rec_step = RS_FLAG;
                else if (i_rx_byte == w_check) w_rec_step = RS_BCC;
            end
            RS_BCC: begin
                w_hit = (i_rx_byte == i_cfg.flag);
            end
            default: begin
            end
        endcase
    end

    // pick the burst of results for this item
    always_comb begin
        o_burst = BURST_NONE;
        case (t_op'(i_opcode))
            OP_START: o_burst = BURST_SET;
            OP_RX: begin
                if (w_wait && w_hit) o_burst = BURST_UP;
            end
            OP_TICK: begin
                if (w_wait && (r_ticks <= ByteW'(1))) begin
                    o_burst = (r_att >= w_limit) ? BURST_FAIL : BURST_SET;
                end
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_rec   = r_rec;
        n_ticks = r_ticks;
        n_att   = r_att;
        case (o_burst)
            BURST_SET: begin
                n_phase = PH_WAIT;
                n_ticks = w_reload;
            end
            BURST_UP: begin
                n_phase = PH_UP;
                n_ticks = '0;
            end
            BURST_FAIL: begin
                n_phase = PH_FAIL;
                n_ticks = '0;
            end
            default: begin
                if (t_op'(i_opcode) == OP_TICK && w_wait) n_ticks = r_ticks - ByteW'(1);
            end
        endcase
        case (t_op'(i_opcode))
            OP_START: begin
                n_rec = RS_START;
                n_att = AttW'(1);
            end
            OP_RX: begin
                if (w_wait) n_rec = w_rec_step;
            end
            OP_TICK: begin
                if (o_burst == BURST_SET) n_att = r_att + AttW'(1);
            end
            default: begin
            end
        endcase
    end

    // hold state between accepted items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_rec   <= RS_START;
            r_ticks <= '0;
            r_att   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_rec   <= n_rec;
            r_ticks <= n_ticks;
            r_att   <= n_att;
        end
    end

`ifndef SYNTHESIS
    a_wait_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WAIT) |-> (r_ticks != '0))
        else $error("waiting with no ticks left");
    a_wait_att: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WAIT) |-> (r_att != '0))
        else $error("waiting with no attempt made");
    a_done_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_UP || r_phase == PH_FAIL) |-> (r_ticks == '0))
        else $error("timer left armed after handshake end");
`endif

endmodule

// ----- hw/rtl/lsu_tx.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsu_tx: result serialiser
// Holds one burst and hands out its result items one per cycle while not
// stalled: five SET frame bytes, or a single link-up or link-failed report.
// ----------------------------------------------------------------------------
module lsu_tx (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  lsu_pkg::t_burst             i_burst,
    input  lsu_pkg::t_cfg               i_cfg,
    input  logic                        i_out_ready,
    output logic                        o_valid,
    output logic [lsu_pkg::KindW-1:0]   o_kind,
    output logic [lsu_pkg::ByteW-1:0]   o_byte,
    output logic                        o_last,
    output logic                        o_can_take
);
    import lsu_pkg::*;

    logic            r_busy;
    t_burst          r_burst;
    logic [IdxW-1:0] r_idx;

    assign o_valid    = r_busy;
    assign o_can_take = !r_busy || (i_out_ready && o_last);

    // build the current result item
    always_comb begin
        o_kind = RK_TX;
        o_byte = '0;
        o_last = 1'b1;
        case (r_burst)
            BURST_SET: begin
                o_last = (r_idx == FrameLastIdx);
                case (r_idx)
                    3'd1:    o_byte = i_cfg.set_addr;
                    3'd2:    o_byte = i_cfg.set_ctrl;
                    3'd3:    o_byte = i_cfg.set_addr ^ i_cfg.set_ctrl;
                    default: o_byte = i_cfg.flag;
                endcase
            end
            BURST_UP:   o_kind = RK_UP;
            BURST_FAIL: o_kind = RK_FAIL;
            default: begin
            end
        endcase
    end

    // load a new burst, advance on each taken item, drop when done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_burst <= BURST_NONE;
            r_idx   <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_burst <= i_burst;
            r_idx   <= '0;
        end else if (r_busy && i_out_ready) begin
            if (o_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + IdxW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_single_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_burst != BURST_SET) |-> (r_idx == '0))
        else $error("single report with non-zero position");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= FrameLastIdx))
        else $error("frame position past closing flag");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_out_ready) |=>
            (r_busy && r_idx == $past(r_idx) && r_burst == $past(r_burst)))
        else $error("burst moved while stalled");
`endif

endmodule

// ----- hw/rtl/link_setup_set_ua_handshake.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_setup_set_ua_handshake: sender side of a SET/UA link set-up
// Sends SET frames, watches received bytes for UA, retries on timeout and
// reports link up or link failed.
// ----------------------------------------------------------------------------
// channel   dir   payload                          taken when
// i_in      in    opcode, rx_byte                  valid & ready
// o_out     out   result_kind, tx_byte, last       valid & ready
// i_cfg     in    addr, data                       valid & ready (ready tied high)
//
// An item is decoded and the state updated in the cycle it is taken; its
// results leave from the serialiser register from the next cycle on.
// Items raising no result or one result go at one per cycle while o_out is
// ready; a SET burst occupies the serialiser for five taken result items.
// A new item is taken in the cycle the last result of the previous burst goes.
// Synchronous active-low reset returns to idle with the register defaults.
// ----------------------------------------------------------------------------
module link_setup_set_ua_handshake (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lsu_in_if.sink    i_in,
    lsu_out_if.source o_out,
    lsu_cfg_if.sink   i_cfg
);
    import lsu_pkg::*;

    t_cfg   w_cfg;
    t_burst w_burst;
    logic   w_fire;
    logic   w_can_take;

    assign i_in.ready = w_can_take;
    assign w_fire     = i_in.valid && w_can_take;

    // configuration registers
    lsu_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid && i_cfg.ready),
        .i_addr  (i_cfg.addr),
        .i_data  (i_cfg.data),
        .o_ready (i_cfg.ready),
        .o_cfg   (w_cfg)
    );

    // handshake state
    lsu_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_opcode  (i_in.opcode),
        .i_rx_byte (i_in.rx_byte),
        .i_cfg     (w_cfg),
        .o_burst   (w_burst)
    );

    // result serialiser
    lsu_tx u_tx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_fire && (w_burst != BURST_NONE)),
        .i_burst     (w_burst),
        .i_cfg       (w_cfg),
        .i_out_ready (o_out.ready),
        .o_valid     (o_out.valid),
        .o_kind      (o_out.result_kind),
        .o_byte      (o_out.tx_byte),
        .o_last      (o_out.last),
        .o_can_take  (w_can_take)
    );

endmodule

// ----- tb/lsu_link_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsu_link_checker: result checker for the SET/UA link set-up block
// Watches the input, result and configuration channels. Keeps its own copy of
// the registers and of the handshake state, works out the results of every
// taken input item and compares each taken result item field by field.
// ----------------------------------------------------------------------------
module lsu_link_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    lsu_in_if    i_in,
    lsu_out_if   i_out,
    lsu_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    import lsu_pkg::*;

    typedef struct packed {
        t_kind            kind;
        logic [ByteW-1:0] tx_byte;
        logic             last;
    } t_line_result;

    t_line_result     results_due[$];
    t_cfg             regs_q;
    t_phase           phase_q;
    t_rec             rec_q;
    logic [ByteW-1:0] ticks_q;
    logic [AttW-1:0]  attempts_q;
    int               fail_count;

    // queue a whole SET frame and arm the timeout
    function automatic void queue_set_frame();
        logic [4:0][ByteW-1:0] frame;
        frame = {regs_q.flag, regs_q.set_addr ^ regs_q.set_ctrl, regs_q.set_ctrl,
                 regs_q.set_addr, regs_q.flag};
        for (int k = 0; k < 5; k++)
            results_due.push_back('{kind: RK_TX, tx_byte: frame[k],
                                    last: (k == FrameLastIdx)});
        ticks_q    = (regs_q.timeout == '0) ? 8'd1 : regs_q.timeout;
        attempts_q = attempts_q + 1'b1;
        phase_q    = PH_WAIT;
    endfunction

    // advance the UA recogniser by one line byte; high on the closing flag
    function automatic logic ua_closed(input logic [ByteW-1:0] b);
        logic [ByteW-1:0] bcc;
        logic             hit;
        bcc = regs_q.reply_addr ^ regs_q.reply_ctrl;
        hit = 1'b0;
        case (rec_q)
            RS_START: begin
                if (b == regs_q.flag) rec_q = RS_FLAG;
            end
            RS_FLAG: begin
                if (b == regs_q.reply_addr) rec_q = RS_ADDR;
                else if (b != regs_q.flag) rec_q = RS_START;
            end
            RS_ADDR: begin
                if (b == regs_q.flag) rec_q = RS_FLAG;
                else if (b == regs_q.reply_ctrl) rec_q = RS_CTRL;
                else rec_q = RS_START;
            end
            RS_CTRL: begin
                if (b == regs_q.flag) rec_q = RS_FLAG;
                else if (b == bcc) rec_q = RS_BCC;
                else rec_q = RS_START;
            end
            RS_BCC: begin
                rec_q = RS_START;
                hit   = (b == regs_q.flag);
            end
            default: begin
                rec_q = RS_START;
            end
        endcase
        return hit;
    endfunction

    // work out the results of one taken input item
    function automatic void predict_item(input logic [OpW-1:0] op,
                                         input logic [ByteW-1:0] b);
        logic [AttW-1:0] limit;
        if (op == OP_START) begin
            rec_q      = RS_START;
            attempts_q = '0;
            queue_set_frame();
        end else if (phase_q == PH_WAIT) begin
            if (op == OP_RX) begin
                if (ua_closed(b)) begin
                    phase_q = PH_UP;
                    ticks_q = '0;
                    results_due.push_back('{kind: RK_UP, tx_byte: '0, last: 1'b1});
                end
            end else if (op == OP_TICK) begin
                if (ticks_q > 8'd1) begin
                    ticks_q = ticks_q - 1'b1;
                end else begin
                    ticks_q = '0;
                    limit   = (regs_q.max_att == '0) ? 4'd1 : regs_q.max_att;
                    if (attempts_q >= limit) begin
                        phase_q = PH_FAIL;
                        results_due.push_back('{kind: RK_FAIL, tx_byte: '0, last: 1'b1});
                    end else begin
                        queue_set_frame();
                    end
                end
            end
        end
    endfunction

    // compare one taken result item with the oldest one due
    function automatic void check_result();
        t_line_result want;
        if (results_due.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result item kind=%0d tx_byte=%02h last=%0b",
                     $time, i_out.result_kind, i_out.tx_byte, i_out.last);
            return;
        end
        want = results_due.pop_front();
        if (i_out.result_kind != want.kind) begin
            fail_count++;
            $display("%0t: result_kind expected %0d got %0d",
                     $time, want.kind, i_out.result_kind);
        end
        if (i_out.tx_byte != want.tx_byte) begin
            fail_count++;
            $display("%0t: tx_byte expected %02h got %02h",
                     $time, want.tx_byte, i_out.tx_byte);
        end
        if (i_out.last != want.last) begin
            fail_count++;
            $display("%0t: last expected %0b got %0b", $time, want.last, i_out.last);
        end
    endfunction

    // track registers, retire results, then predict the newly taken item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs_q     = '{flag: FlagReset, set_addr: SetAddrReset, set_ctrl: SetCtrlReset,
                           reply_addr: ReplyAddrReset, reply_ctrl: ReplyCtrlReset,
                           timeout: TimeoutReset, max_att: MaxAttReset};
            phase_q    = PH_IDLE;
            rec_q      = RS_START;
            ticks_q    = '0;
            attempts_q = '0;
            results_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_addr'(i_cfg.addr))
                    CA_FLAG:       regs_q.flag       = i_cfg.data;
                    CA_SET_ADDR:   regs_q.set_addr   = i_cfg.data;
                    CA_SET_CTRL:   regs_q.set_ctrl   = i_cfg.data;
                    CA_REPLY_ADDR: regs_q.reply_addr = i_cfg.data;
                    CA_REPLY_CTRL: regs_q.reply_ctrl = i_cfg.data;
                    CA_TIMEOUT:    regs_q.timeout    = i_cfg.data;
                    CA_MAX_ATT:    regs_q.max_att    = i_cfg.data[AttW-1:0];
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready)
                check_result();
            if (i_in.valid && i_in.ready)
                predict_item(i_in.opcode, i_in.rx_byte);
        end
        o_fail_count <= fail_count;
        o_pending    <= results_due.size();
    end

    initial begin
        fail_count   = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

endmodule

// ----- tb/link_setup_set_ua_handshake_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_setup_set_ua_handshake_tb: stimulus and verdict for the SET/UA block
// Runs directed handshakes (link up, UA spanning a resend, restart, failure)
// then random SET/UA exchanges under several register settings, with random
// gaps on both sides, a long receiver hold-off and a no-progress watchdog.
// ----------------------------------------------------------------------------
module link_setup_set_ua_handshake_tb;
    import lsu_pkg::*;

    localparam logic [OpW-1:0] OpUnused      = 2'd3;
    localparam int             StallPct      = 12;
    localparam int             HoldOffCycles = 80;
    localparam int             SettleCycles  = 4;
    localparam int             WatchdogLimit = 2000;
    localparam int             PhaseItems    = 88;

    logic i_clk;
    logic i_rst_n;

    lsu_in_if  in_ch ();
    lsu_out_if out_ch ();
    lsu_cfg_if cfg_ch ();

    int   fail_count;
    int   results_pending;
    int   items_sent;
    int   quiet_cycles;
    bit   idle_en;
    bit   hold_off;
    t_cfg regs_now;

    link_setup_set_ua_handshake u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    lsu_link_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: random stalls, none while idling is off, held low on hold-off
    always @(negedge i_clk) begin
        if (hold_off) out_ch.ready <= 1'b0;
        else if (idle_en) out_ch.ready <= ($urandom_range(0, 99) >= StallPct);
        else out_ch.ready <= 1'b1;
    end

    // hold off the result side for a long stretch mid-run so the input stalls
    initial begin
        hold_off = 1'b0;
        wait (items_sent >= 200);
        @(negedge i_clk);
        hold_off <= 1'b1;
        repeat (HoldOffCycles) @(negedge i_clk);
        hold_off <= 1'b0;
    end

    // drop the run if nothing moves on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("%0t: no progress for %0d cycles", $time, WatchdogLimit);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one input item and hold it until taken
    task automatic send_item(input logic [OpW-1:0] op, input logic [ByteW-1:0] b);
        while (idle_en && $urandom_range(0, 99) < StallPct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.opcode  <= op;
        in_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_addr idx, input logic [ByteW-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.data  <= d;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // write every register, only with nothing in flight
    task automatic load_regs(input t_cfg c);
        write_reg(CA_FLAG, c.flag);
        write_reg(CA_SET_ADDR, c.set_addr);
        write_reg(CA_SET_CTRL, c.set_ctrl);
        write_reg(CA_REPLY_ADDR, c.reply_addr);
        write_reg(CA_REPLY_CTRL, c.reply_ctrl);
        write_reg(CA_TIMEOUT, c.timeout);
        write_reg(CA_MAX_ATT, {4'd0, c.max_att});
        cfg_ch.valid <= 1'b0;
        regs_now = c;
    endtask

    // stop offering and wait until every result has gone, then let the block settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (results_pending != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    // send the first n_bytes of a UA frame with stray ticks, spoiling byte spoil_at
    task automatic send_ua(input int n_bytes, input int spoil_at, input int tick_pct);
        logic [4:0][ByteW-1:0] frame;
        logic [ByteW-1:0]      b;
        frame = {regs_now.flag, regs_now.reply_addr ^ regs_now.reply_ctrl,
                 regs_now.reply_ctrl, regs_now.reply_addr, regs_now.flag};
        for (int k = 0; k < n_bytes; k++) begin
            if ($urandom_range(0, 99) < tick_pct)
                send_item(OP_TICK, 8'($urandom));
            b = frame[k];
            if (k == spoil_at)
                b = b ^ 8'($urandom_range(1, 255));
            send_item(OP_RX, b);
        end
    endtask

    // random exchanges: mostly clean SET/UA, some timeouts, broken frames and noise
    task automatic run_exchanges(input int n_items);
        int stop_at;
        int pick;
        int ticks;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_item(OP_START, 8'($urandom));
                repeat ($urandom_range(0, 2)) send_item(OP_TICK, 8'($urandom));
                send_ua(5, 5, 15);
            end else if (pick < 68) begin
                send_item(OP_START, 8'($urandom));
                ticks = ((regs_now.timeout == 0) ? 1 : regs_now.timeout)
                      * ((regs_now.max_att == 0) ? 1 : regs_now.max_att) + 1;
                if (ticks > 14)
                    ticks = $urandom_range(1, 14);
                repeat (ticks) send_item(OP_TICK, 8'($urandom));
            end else if (pick < 85) begin
                send_item(OP_START, 8'($urandom));
                send_ua($urandom_range(1, 5), $urandom_range(0, 4), 10);
            end else begin
                repeat ($urandom_range(1, 6))
                    send_item(OpW'($urandom_range(0, 3)), 8'($urandom));
            end
        end
    endtask

    initial begin
        in_ch.valid    = 1'b0;
        in_ch.opcode   = OP_START;
        in_ch.rx_byte  = '0;
        out_ch.ready   = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.addr    = CA_FLAG;
        cfg_ch.data    = '0;
        i_rst_n        = 1'b0;
        idle_en        = 1'b1;
        items_sent     = 0;
        quiet_cycles   = 0;
        regs_now       = '{flag: FlagReset, set_addr: SetAddrReset, set_ctrl: SetCtrlReset,
                           reply_addr: ReplyAddrReset, reply_ctrl: ReplyCtrlReset,
                           timeout: TimeoutReset, max_att: MaxAttReset};
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset registers: ignored items while idle, link up with UA spanning a resend
        send_item(OP_RX, FlagReset);
        send_item(OP_TICK, 8'hff);
        send_item(OpUnused, 8'h55);
        send_item(OP_START, 8'h00);
        send_item(OP_RX, FlagReset);
        send_item(OP_RX, ReplyAddrReset);
        repeat (5) send_item(OP_TICK, 8'h00);
        send_item(OP_RX, ReplyCtrlReset);
        send_item(OP_RX, ReplyAddrReset ^ ReplyCtrlReset);
        send_item(OP_RX, FlagReset);
        send_item(OP_RX, 8'h00);
        send_item(OP_TICK, 8'h00);
        // restart in the middle of a handshake
        send_item(OP_START, 8'hff);
        send_item(OP_RX, 8'hff);
        send_item(OP_START, 8'h00);
        drain();

        // zero timeout and zero attempts: fail on the first tick, then ignore
        load_regs('{flag: 8'h00, set_addr: 8'hff, set_ctrl: 8'h00, reply_addr: 8'hff,
                    reply_ctrl: 8'hff, timeout: 8'd0, max_att: 4'd0});
        send_item(OP_START, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_item(OP_TICK, 8'hff);
        send_item(OP_RX, 8'h00);
        send_item(OpUnused, 8'haa);
        drain();

        // top of every range but the reply bytes
        load_regs('{flag: 8'hff, set_addr: 8'hff, set_ctrl: 8'hff, reply_addr: 8'hfe,
                    reply_ctrl: 8'h80, timeout: 8'd255, max_att: 4'd15});
        run_exchanges(PhaseItems);
        drain();

        // flag and SET bytes at the bottom, single attempt with a one-tick timeout
        load_regs('{flag: 8'h00, set_addr: 8'h00, set_ctrl: 8'h00, reply_addr: 8'h01,
                    reply_ctrl: 8'h02, timeout: 8'd1, max_att: 4'd1});
        run_exchanges(PhaseItems);
        drain();

        // random bytes, short retries, no idling on either side
        idle_en = 1'b0;
        load_regs('{flag: 8'($urandom), set_addr: 8'($urandom), set_ctrl: 8'($urandom),
                    reply_addr: 8'($urandom), reply_ctrl: 8'($urandom),
                    timeout: 8'($urandom_range(2, 4)), max_att: 4'($urandom_range(2, 3))});
        run_exchanges(PhaseItems);
        drain();
        idle_en = 1'b1;

        // reply address equal to the flag byte
        regs_now.flag = 8'($urandom);
        load_regs('{flag: regs_now.flag, set_addr: 8'($urandom), set_ctrl: 8'($urandom),
                    reply_addr: regs_now.flag, reply_ctrl: 8'($urandom),
                    timeout: 8'($urandom_range(1, 3)), max_att: 4'($urandom_range(1, 15))});
        run_exchanges(PhaseItems);
        drain();

        if (fail_count == 0 && results_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
